// ----- hdl/meq_pkg.sv -----
`default_nettype none
package meq_pkg;

  localparam logic [2:0] KIND_POST  = 3'd0;
  localparam logic [2:0] KIND_GET   = 3'd1;
  localparam logic [2:0] KIND_PEEK  = 3'd2;
  localparam logic [2:0] KIND_FLUSH = 3'd3;
  localparam logic [2:0] KIND_FGET  = 3'd4;

  localparam logic [3:0] REUSE_TYPE = 4'd12;
  localparam logic [3:0] NULL_TYPE  = 4'd0;

  typedef struct packed {
    logic [3:0]  ev_type;
    logic [31:0] message;
    logic [31:0] stamp;
    logic [31:0] where;
  } rec_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic walk_init;
    logic rd;
    logic rd_free;
    logic advance;
    logic save_nxt;
    logic unlink;
    logic free_push;
    logic step_next;
    logic fb_init;
    logic a_free;
    logic append;
    logic resp;
    logic resp_found;
    logic use_fl;
    logic no_limit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic full;
    logic left_zero;
    logic is_reuse;
    logic hit;
    logic late;
    logic null_type;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/meq_ctrl.sv -----
`default_nettype none
module meq_ctrl
  import meq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [2:0] in_kind,
  input  sts_t            sts,
  output cmd_t            cmd,
  output logic            busy
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WRD  = 4'd2;
  localparam logic [3:0] S_WEV  = 4'd3;
  localparam logic [3:0] S_UNL  = 4'd4;
  localparam logic [3:0] S_FPU  = 4'd5;
  localparam logic [3:0] S_FBRD = 4'd6;
  localparam logic [3:0] S_FBEV = 4'd7;
  localparam logic [3:0] S_ARD  = 4'd8;
  localparam logic [3:0] S_AFR  = 4'd9;
  localparam logic [3:0] S_APP  = 4'd10;
  localparam logic [3:0] S_RSP  = 4'd11;

  localparam logic [1:0] M_REUSE = 2'd0;
  localparam logic [1:0] M_GET   = 2'd1;
  localparam logic [1:0] M_FLUSH = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       take_r, take_nxt;
  logic       fg_r, fg_nxt;
  logic       found_r, found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      mode_r  <= M_GET;
      take_r  <= 1'b0;
      fg_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      take_r  <= take_nxt;
      fg_r    <= fg_nxt;
      found_r <= found_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    mode_nxt  = mode_r;
    take_nxt  = take_r;
    fg_nxt    = fg_r;
    found_nxt = found_r;
    cmd.use_fl   = (mode_r == M_FLUSH) && fg_r;
    cmd.no_limit = fg_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          fg_nxt    = 1'b0;
          found_nxt = 1'b0;
          priority case (in_kind)
            KIND_POST: begin
              if (sts.full) begin
                mode_nxt      = M_REUSE;
                cmd.walk_init = 1'b1;
                state_nxt     = S_WRD;
              end else begin
                state_nxt = S_ARD;
              end
            end
            KIND_GET, KIND_PEEK: begin
              mode_nxt      = M_GET;
              take_nxt      = (in_kind == KIND_GET);
              cmd.walk_init = 1'b1;
              state_nxt     = S_WRD;
            end
            KIND_FLUSH, KIND_FGET: begin
              mode_nxt      = M_FLUSH;
              fg_nxt        = (in_kind == KIND_FGET);
              cmd.walk_init = 1'b1;
              state_nxt     = S_WRD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRD: begin
        if (sts.left_zero) begin
          unique case (mode_r)
            M_REUSE: begin
              cmd.fb_init = 1'b1;
              state_nxt   = S_FBRD;
            end
            M_FLUSH: begin
              if (fg_r) begin
                mode_nxt      = M_GET;
                take_nxt      = 1'b1;
                cmd.walk_init = 1'b1;
                state_nxt     = S_WRD;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            default: state_nxt = S_RSP;
          endcase
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_WEV;
        end
      end
      S_WEV: begin
        cmd.save_nxt = 1'b1;
        unique case (mode_r)
          M_REUSE: begin
            if (sts.is_reuse) begin
              state_nxt = S_UNL;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = S_WRD;
            end
          end
          M_FLUSH: begin
            if (sts.late) begin
              if (fg_r) begin
                mode_nxt      = M_GET;
                take_nxt      = 1'b1;
                cmd.walk_init = 1'b1;
                state_nxt     = S_WRD;
              end else begin
                state_nxt = S_IDLE;
              end
            end else if (sts.hit) begin
              state_nxt = S_UNL;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = S_WRD;
            end
          end
          default: begin
            if (sts.hit) begin
              found_nxt = !sts.null_type;
              state_nxt = (!sts.null_type && take_r) ? S_UNL : S_RSP;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = S_WRD;
            end
          end
        endcase
      end
      S_UNL: begin
        cmd.unlink = 1'b1;
        state_nxt  = (mode_r == M_REUSE) ? S_APP : S_FPU;
      end
      S_FPU: begin
        cmd.free_push = 1'b1;
        if (mode_r == M_FLUSH) begin
          cmd.step_next = 1'b1;
          state_nxt     = S_WRD;
        end else begin
          state_nxt = S_RSP;
        end
      end
      S_FBRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FBEV;
      end
      S_FBEV: begin
        cmd.save_nxt = 1'b1;
        state_nxt    = S_UNL;
      end
      S_ARD: begin
        cmd.rd      = 1'b1;
        cmd.rd_free = 1'b1;
        state_nxt   = S_AFR;
      end
      S_AFR: begin
        cmd.a_free = 1'b1;
        state_nxt  = S_APP;
      end
      S_APP: begin
        cmd.append = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RSP: begin
        cmd.resp       = 1'b1;
        cmd.resp_found = found_r;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RSP) |=> (state_r == S_IDLE))
    else $error("Response state did not return to idle.");
  a_append_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> !busy)
    else $error("Append did not end the item.");
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $past(rst_n) && (state_r == S_IDLE))
    else $error("Item loaded outside idle.");
`endif

endmodule
`default_nettype wire

// ----- hdl/meq_dp.sv -----
`default_nettype none
module meq_dp
  import meq_pkg::*;
#(
  parameter int POOL_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  wire logic [3:0]  in_event_type,
  input  wire logic [31:0] in_event_message,
  input  wire logic [31:0] in_event_time,
  input  wire logic [31:0] in_event_where,
  input  wire logic [15:0] in_select_mask,
  input  wire logic [15:0] in_flush_mask,
  input  wire logic [31:0] in_time_limit,
  output logic             out_valid,
  output logic             out_found,
  output logic [3:0]       out_type,
  output logic [31:0]      out_message,
  output logic [31:0]      out_time,
  output logic [31:0]      out_where
);

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_DEPTH);

  logic [IDX_W-1:0] link_mem [POOL_DEPTH];
  rec_t             data_mem [POOL_DEPTH];

  logic [IDX_W-1:0] head_r, tail_r, free_r, clr_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] cur_r, prev_r, nxt_r;
  logic             has_prev_r;
  logic [CNT_W-1:0] left_r;
  logic [IDX_W-1:0] link_rd_r;
  rec_t             rec_rd_r;
  rec_t             in_rec_r;
  logic [15:0]      sel_r, fl_r;
  logic [31:0]      limit_r;

  logic             out_valid_r, out_found_r;
  rec_t             out_rec_r;

  logic             lw_en;
  logic [IDX_W-1:0] lw_addr, lw_data, rd_addr;
  logic [15:0]      act_mask;

  assign rd_addr  = cmd.rd_free ? free_r : cur_r;
  assign act_mask = cmd.use_fl ? fl_r : sel_r;

  always_comb begin
    lw_en   = 1'b1;
    lw_addr = clr_r;
    lw_data = (clr_r == LAST_IDX) ? '0 : clr_r + 1'b1;
    if (cmd.clr_step) begin
      lw_en = 1'b1;
    end else if (cmd.unlink) begin
      lw_en   = has_prev_r;
      lw_addr = prev_r;
      lw_data = nxt_r;
    end else if (cmd.free_push) begin
      lw_addr = cur_r;
      lw_data = free_r;
    end else if (cmd.append) begin
      lw_en   = (count_r != '0);
      lw_addr = tail_r;
      lw_data = cur_r;
    end else begin
      lw_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (cmd.append) begin
      data_mem[cur_r] <= in_rec_r;
    end
    if (cmd.rd) begin
      link_rd_r <= link_mem[rd_addr];
      rec_rd_r  <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp;
      if (cmd.resp) begin
        out_found_r <= cmd.resp_found;
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.unlink) begin
        if (!has_prev_r) begin
          head_r <= nxt_r;
        end
        if (has_prev_r && (cur_r == tail_r)) begin
          tail_r <= prev_r;
        end
        count_r <= count_r - 1'b1;
      end
      if (cmd.free_push) begin
        free_r <= cur_r;
      end
      if (cmd.a_free) begin
        free_r <= link_rd_r;
      end
      if (cmd.append) begin
        if (count_r == '0) begin
          head_r <= cur_r;
        end
        tail_r  <= cur_r;
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_rec_r <= '{ev_type: in_event_type, message: in_event_message,
                    stamp: in_event_time, where: in_event_where};
      sel_r    <= in_select_mask;
      fl_r     <= in_flush_mask;
      limit_r  <= in_time_limit;
    end
    if (cmd.walk_init) begin
      cur_r      <= head_r;
      has_prev_r <= 1'b0;
      left_r     <= count_r;
    end
    if (cmd.fb_init) begin
      cur_r      <= head_r;
      has_prev_r <= 1'b0;
    end
    if (cmd.save_nxt) begin
      nxt_r <= link_rd_r;
    end
    if (cmd.advance) begin
      prev_r     <= cur_r;
      has_prev_r <= 1'b1;
      cur_r      <= link_rd_r;
      left_r     <= left_r - 1'b1;
    end
    if (cmd.step_next) begin
      cur_r  <= nxt_r;
      left_r <= left_r - 1'b1;
    end
    if (cmd.a_free) begin
      cur_r <= free_r;
    end
    if (cmd.resp) begin
      out_rec_r <= cmd.resp_found ? rec_rd_r : '0;
    end
  end

  assign sts.clr_done  = (clr_r == LAST_IDX);
  assign sts.full      = (count_r == FULL_CNT);
  assign sts.left_zero = (left_r == '0);
  assign sts.is_reuse  = (rec_rd_r.ev_type == REUSE_TYPE);
  assign sts.hit       = act_mask[rec_rd_r.ev_type];
  assign sts.late      = !cmd.no_limit && (rec_rd_r.stamp > limit_r);
  assign sts.null_type = (rec_rd_r.ev_type == NULL_TYPE);

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_type    = out_rec_r.ev_type;
  assign out_message = out_rec_r.message;
  assign out_time    = out_rec_r.stamp;
  assign out_where   = out_rec_r.where;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("Queued count exceeds the pool.");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (count_r != FULL_CNT))
    else $error("Append into a full pool.");
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_type == NULL_TYPE) && (out_time == '0))
    else $error("Empty result carries data.");
`endif

endmodule
`default_nettype wire

// ----- hdl/masked_event_queue_core.sv -----
`default_nettype none
// Post with a free slot appends it from the free list; with a full pool it
// walks the queue for a reuse-type event, else takes the head, and reuses that
// slot. Get and peek walk the queue; flush then get walks it for the flush and
// again for the get. Each walk step costs one registered read of the link and
// event memories. After reset a clearing pass rebuilds the free list; busy is
// high meanwhile. A result is shown for one cycle; the receiver cannot stall.
module masked_event_queue_core
  import meq_pkg::*;
#(
  parameter int POOL_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [3:0]  in_event_type,
  input  wire logic [31:0] in_event_message,
  input  wire logic [31:0] in_event_time,
  input  wire logic [31:0] in_event_where,
  input  wire logic [15:0] in_select_mask,
  input  wire logic [15:0] in_flush_mask,
  input  wire logic [31:0] in_time_limit,
  output logic             out_valid,
  output logic             out_found,
  output logic [3:0]       out_type,
  output logic [31:0]      out_message,
  output logic [31:0]      out_time,
  output logic [31:0]      out_where
);

  cmd_t cmd;
  sts_t sts;

  meq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  meq_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_event_type    (in_event_type),
    .in_event_message (in_event_message),
    .in_event_time    (in_event_time),
    .in_event_where   (in_event_where),
    .in_select_mask   (in_select_mask),
    .in_flush_mask    (in_flush_mask),
    .in_time_limit    (in_time_limit),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_type         (out_type),
    .out_message      (out_message),
    .out_time         (out_time),
    .out_where        (out_where)
  );

endmodule
`default_nettype wire
